/* hw/rtl/hlst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlst_pkg
// Shared types, field widths and status codes of the held-lock stack tracker.
// ----------------------------------------------------------------------------
package hlst_pkg;

  localparam int unsigned ID_W     = 10;
  localparam int unsigned DEPTH_W  = 6;
  localparam int unsigned STATUS_W = 3;

  typedef logic [ID_W-1:0]     lock_id_t;
  typedef logic [DEPTH_W-1:0]  depth_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam logic MODE_PUSH   = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam status_t ST_PUSHED        = 3'd0;
  localparam status_t ST_OVERFLOW      = 3'd1;
  localparam status_t ST_REMOVED_TOP   = 3'd2;
  localparam status_t ST_REMOVED_INNER = 3'd3;
  localparam status_t ST_NOT_HELD      = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic    latch;     // capture input transaction, pointer <= count
    logic    push_wr;   // write id on top, count + 1
    logic    rd_dec;    // pointer - 1, read entry there
    logic    rd_up;     // read entry above pointer
    logic    sh_wr;     // write read data at pointer, pointer + 1
    logic    cnt_dec;   // count - 1
    logic    set_st;    // capture status code
    status_t st;
    logic    load_out;  // load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic remove;
    logic full;
    logic empty;
    logic match;
    logic at_top;
    logic at_bottom;
    logic shift_last;
  } sts_t;

endpackage

/* hw/rtl/hlst_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlst_in_if
// Request channel: push or remove of one lock identifier.
// ----------------------------------------------------------------------------
interface hlst_in_if;
  logic              valid;
  logic              ready;
  logic              mode;
  hlst_pkg::lock_id_t lock_id;

  modport source (output valid, output mode, output lock_id, input ready);
  modport sink   (input valid, input mode, input lock_id, output ready);
endinterface

/* hw/rtl/hlst_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlst_out_if
// Result channel: status code and stack depth after the operation.
// ----------------------------------------------------------------------------
interface hlst_out_if;
  logic              valid;
  logic              ready;
  hlst_pkg::status_t status;
  hlst_pkg::depth_t  depth;

  modport source (output valid, output status, output depth, input ready);
  modport sink   (input valid, input status, input depth, output ready);
endinterface

/* hw/rtl/hlst_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlst_datapath
// Stack memory, depth counter, scan pointer and result register.
// ----------------------------------------------------------------------------
module hlst_datapath #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hlst_pkg::cmd_t     cmd_i,
  output hlst_pkg::sts_t     sts_o,
  input  logic               in_mode_i,
  input  hlst_pkg::lock_id_t in_lock_id_i,
  output hlst_pkg::status_t  out_status_o,
  output hlst_pkg::depth_t   out_depth_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DW = hlst_pkg::DEPTH_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE      = CW'(1);

  hlst_pkg::lock_id_t mem_q [STACK_DEPTH];
  hlst_pkg::lock_id_t rdata_q;
  hlst_pkg::lock_id_t id_q;
  logic               mode_q;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      ptr_q, ptr_d;
  hlst_pkg::status_t  status_q;
  hlst_pkg::status_t  out_status_q;
  hlst_pkg::depth_t   out_depth_q;

  logic               we;
  logic [CW-1:0]      waddr;
  hlst_pkg::lock_id_t wdata;
  logic               re;
  logic [CW-1:0]      raddr;

  always_comb begin
    we      = 1'b0;
    waddr   = count_q;
    wdata   = id_q;
    re      = 1'b0;
    raddr   = ptr_q + ONE;
    ptr_d   = ptr_q;
    count_d = count_q;
    if (cmd_i.latch) begin
      ptr_d = count_q;
    end
    if (cmd_i.push_wr) begin
      we      = 1'b1;
      count_d = count_q + ONE;
    end
    if (cmd_i.rd_dec) begin
      re    = 1'b1;
      raddr = ptr_q - ONE;
      ptr_d = ptr_q - ONE;
    end
    if (cmd_i.rd_up) begin
      re = 1'b1;
    end
    if (cmd_i.sh_wr) begin
      // move the entry above the hole down by one
      we    = 1'b1;
      waddr = ptr_q;
      wdata = rdata_q;
      ptr_d = ptr_q + ONE;
    end
    if (cmd_i.cnt_dec) begin
      count_d = count_q - ONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr[AW-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= mem_q[raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.latch) begin
      mode_q <= in_mode_i;
      id_q   <= in_lock_id_i;
    end
    if (cmd_i.set_st) begin
      status_q <= cmd_i.st;
    end
    if (cmd_i.load_out) begin
      out_status_q <= status_q;
      out_depth_q  <= DW'(count_q);
    end
  end

  always_comb begin
    sts_o.remove     = (mode_q == hlst_pkg::MODE_REMOVE);
    sts_o.full       = (count_q == FULL_CNT);
    sts_o.empty      = (count_q == '0);
    sts_o.match      = (rdata_q == id_q);
    sts_o.at_top     = (ptr_q == (count_q - ONE));
    sts_o.at_bottom  = (ptr_q == '0);
    sts_o.shift_last = ((ptr_q + ONE) == (count_q - ONE));
  end

  assign out_status_o = out_status_q;
  assign out_depth_o  = out_depth_q;

endmodule

/* hw/rtl/hlst_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlst_ctrl
// Sequencer for push, downward search and shift-down of the stack.
// ----------------------------------------------------------------------------
module hlst_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  hlst_pkg::sts_t sts_i,
  output hlst_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_CMP    = 3'd2;
  localparam logic [2:0] S_SHWR   = 3'd3;
  localparam logic [2:0] S_SHRD   = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    cmd_o.st    = hlst_pkg::ST_PUSHED;
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.set_st = 1'b1;
        if (!sts_i.remove) begin
          state_d = S_FIN;
          if (sts_i.full) begin
            cmd_o.st = hlst_pkg::ST_OVERFLOW;
          end else begin
            cmd_o.push_wr = 1'b1;
            cmd_o.st      = hlst_pkg::ST_PUSHED;
          end
        end else if (sts_i.empty) begin
          cmd_o.st = hlst_pkg::ST_NOT_HELD;
          state_d  = S_FIN;
        end else begin
          cmd_o.set_st = 1'b0;
          cmd_o.rd_dec = 1'b1;
          state_d      = S_CMP;
        end
      end
      S_CMP: begin
        // read data belongs to the entry at the pointer
        if (sts_i.match) begin
          if (sts_i.at_top) begin
            cmd_o.cnt_dec = 1'b1;
            cmd_o.set_st  = 1'b1;
            cmd_o.st      = hlst_pkg::ST_REMOVED_TOP;
            state_d       = S_FIN;
          end else begin
            cmd_o.rd_up = 1'b1;
            state_d     = S_SHWR;
          end
        end else if (sts_i.at_bottom) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = hlst_pkg::ST_NOT_HELD;
          state_d      = S_FIN;
        end else begin
          cmd_o.rd_dec = 1'b1;
        end
      end
      S_SHWR: begin
        cmd_o.sh_wr = 1'b1;
        if (sts_i.shift_last) begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.set_st  = 1'b1;
          cmd_o.st      = hlst_pkg::ST_REMOVED_INNER;
          state_d       = S_FIN;
        end else begin
          state_d = S_SHRD;
        end
      end
      S_SHRD: begin
        cmd_o.rd_up = 1'b1;
        state_d     = S_SHWR;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/held_lock_stack_tracker_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// held_lock_stack_tracker_core
// Per-thread stack of held lock ids with push and remove-from-any-position.
// ----------------------------------------------------------------------------
// A push is written in the decode step; a remove reads and compares entries from
// the top down and, on an inner hit, shifts every entry above it down by one.
// One transaction at a time, accepted the cycle after the previous result is
// loaded; loading the result waits while the output is stalled.
// The single-port stack memory (one read or write per cycle) sets this sequence.
// Reset clears the depth counter and handshake state, not the stack memory.
module held_lock_stack_tracker_core #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  hlst_in_if.sink      in_i,
  hlst_out_if.source   out_o
);

  hlst_pkg::cmd_t cmd;
  hlst_pkg::sts_t sts;

  hlst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hlst_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_mode_i    (in_i.mode),
    .in_lock_id_i (in_i.lock_id),
    .out_status_o (out_o.status),
    .out_depth_o  (out_o.depth)
  );

  localparam int unsigned DW = hlst_pkg::DEPTH_W;

  // one transaction in flight: no accept right after an accept
  a_single_txn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted while a transaction is in flight");

  // a refused push always reports a full stack
  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == hlst_pkg::ST_OVERFLOW) |->
      (out_o.depth == DW'(STACK_DEPTH)))
    else $error("overflow reported below full depth");

  // result register is loaded only from the finishing step with a legal code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> (out_o.status == hlst_pkg::ST_PUSHED ||
      out_o.status == hlst_pkg::ST_OVERFLOW ||
      out_o.status == hlst_pkg::ST_REMOVED_TOP ||
      out_o.status == hlst_pkg::ST_REMOVED_INNER ||
      out_o.status == hlst_pkg::ST_NOT_HELD))
    else $error("illegal status code on result");

  // no stack write or depth change while the input side is ready (idle)
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !(cmd.push_wr || cmd.sh_wr || cmd.cnt_dec))
    else $error("stack modified while idle");

endmodule

/* tb/held_lock_stack_tracker_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// held_lock_stack_tracker_core_tb
// Self-checking bench for the held-lock stack tracker. A short table of push
// and remove operations covers the empty stack, the id extremes, duplicates,
// top and inner removes and misses. Random traffic then fills the stack to
// overflow and mixes pushes with removes of held and unheld ids. Every result is
// checked against the row's typed result or a behavioral stack kept in the bench.
// ----------------------------------------------------------------------------
module held_lock_stack_tracker_core_tb;

  localparam int unsigned STACK_DEPTH     = 32;
  localparam int unsigned ITEMS_PER_PHASE = 480;
  localparam int unsigned DIRECTED_ROWS   = 20;
  localparam int unsigned STALL_LIMIT     = 5000;
  localparam int unsigned PRESSURE_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES   = 150;
  localparam int unsigned MAX_SHOWN       = 10;

  typedef struct packed {
    hlst_pkg::status_t status;
    hlst_pkg::depth_t  depth;
  } lock_result_t;

  typedef struct {
    logic               mode;
    hlst_pkg::lock_id_t lock_id;
    bit                 typed;
    hlst_pkg::status_t  status;
    hlst_pkg::depth_t   depth;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hlst_in_if  in_ch ();
  hlst_out_if out_ch ();

  held_lock_stack_tracker_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #1 clk_i = ~clk_i;

  // bench copy of the lock stack
  hlst_pkg::lock_id_t held_stack [STACK_DEPTH];
  int                 held_depth = 0;
  int                 peak_depth = 0;

  lock_result_t outcome_q[$];
  stim_row_t    directed_ops [DIRECTED_ROWS];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          run_phase     = -1;
  int unsigned ops_sent      = 0;
  int unsigned mismatches    = 0;
  int unsigned status_seen [8];

  int unsigned hold_left     = 0;
  bit          pressure_done = 1'b0;

  function automatic lock_result_t predict_lock_op(input logic op_mode,
                                                   input hlst_pkg::lock_id_t op_id);
    lock_result_t res;
    int hit;
    hit = -1;
    if (op_mode == hlst_pkg::MODE_PUSH) begin
      if (held_depth >= STACK_DEPTH) begin
        res.status = hlst_pkg::ST_OVERFLOW;
      end else begin
        held_stack[held_depth] = op_id;
        held_depth++;
        res.status = hlst_pkg::ST_PUSHED;
      end
    end else if (held_depth != 0 && held_stack[held_depth-1] == op_id) begin
      held_depth--;
      res.status = hlst_pkg::ST_REMOVED_TOP;
    end else begin
      // topmost match wins
      for (int k = held_depth - 1; k >= 0 && hit < 0; k--) begin
        if (held_stack[k] == op_id) hit = k;
      end
      if (hit < 0) begin
        res.status = hlst_pkg::ST_NOT_HELD;
      end else begin
        for (int j = hit; j + 1 < held_depth; j++) held_stack[j] = held_stack[j+1];
        held_depth--;
        res.status = hlst_pkg::ST_REMOVED_INNER;
      end
    end
    if (held_depth > peak_depth) peak_depth = held_depth;
    res.depth = hlst_pkg::depth_t'(held_depth);
    return res;
  endfunction

  // small pool for duplicates and hits, full range for bit coverage
  function automatic hlst_pkg::lock_id_t random_lock_id();
    if ($urandom_range(0, 2) == 0) return hlst_pkg::lock_id_t'($urandom);
    return hlst_pkg::lock_id_t'($urandom_range(0, 7));
  endfunction

  task automatic issue_op(input logic op_mode, input hlst_pkg::lock_id_t op_id,
                          input bit typed, input lock_result_t typed_res);
    lock_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= op_mode;
    in_ch.lock_id <= op_id;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predicted = predict_lock_op(op_mode, op_id);
    outcome_q.push_back(typed ? typed_res : predicted);
    ops_sent++;
  endtask

  // result monitor and receiver side
  always @(posedge clk_i) begin
    lock_result_t got;
    lock_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.status = out_ch.status;
      got.depth  = out_ch.depth;
      status_seen[got.status]++;
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: unexpected result status=%0d depth=%0d", $realtime,
                   got.status, got.depth);
      end else begin
        want = outcome_q.pop_front();
        if (got.status !== want.status || got.depth !== want.depth) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("%0t: mismatch status exp=%0d got=%0d, depth exp=%0d got=%0d",
                     $realtime, want.status, got.status, want.depth, got.depth);
        end
      end
    end
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (run_phase == 2 && !pressure_done) begin
      // long back-pressure so the input side stalls
      hold_left     = PRESSURE_CYCLES;
      pressure_done = 1'b1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: %0d cycles without a transaction", STALL_LIMIT);
    $display("** held_lock_stack_tracker_core: FAILED **");
    $finish;
  end

  initial begin
    lock_result_t       row_res;
    logic               op_mode;
    hlst_pkg::lock_id_t op_id;
    int unsigned        push_pct;

    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.mode    = hlst_pkg::MODE_PUSH;
    in_ch.lock_id = '0;
    out_ch.ready  = 1'b0;
    push_pct      = 50;

    directed_ops = '{
      '{hlst_pkg::MODE_REMOVE, 10'h000, 1'b1, hlst_pkg::ST_NOT_HELD, 6'd0}, // empty stack
      '{hlst_pkg::MODE_PUSH, 10'h000, 1'b1, hlst_pkg::ST_PUSHED, 6'd1},
      '{hlst_pkg::MODE_PUSH, 10'h3FF, 1'b1, hlst_pkg::ST_PUSHED, 6'd2},
      '{hlst_pkg::MODE_REMOVE, 10'h3FF, 1'b1, hlst_pkg::ST_REMOVED_TOP, 6'd1},
      '{hlst_pkg::MODE_REMOVE, 10'h3FF, 1'b1, hlst_pkg::ST_NOT_HELD, 6'd1},
      '{hlst_pkg::MODE_PUSH, 10'h155, 1'b1, hlst_pkg::ST_PUSHED, 6'd2},
      '{hlst_pkg::MODE_PUSH, 10'h2AA, 1'b1, hlst_pkg::ST_PUSHED, 6'd3},
      '{hlst_pkg::MODE_PUSH, 10'h000, 1'b1, hlst_pkg::ST_PUSHED, 6'd4}, // duplicate of the bottom
      '{hlst_pkg::MODE_REMOVE, 10'h000, 1'b1, hlst_pkg::ST_REMOVED_TOP, 6'd3},
      '{hlst_pkg::MODE_PUSH, 10'h005, 1'b0, hlst_pkg::ST_PUSHED, 6'd0},
      '{hlst_pkg::MODE_REMOVE, 10'h155, 1'b0, hlst_pkg::ST_PUSHED, 6'd0}, // inner, shifts two down
      '{hlst_pkg::MODE_REMOVE, 10'h000, 1'b0, hlst_pkg::ST_PUSHED, 6'd0}, // bottom entry
      '{hlst_pkg::MODE_PUSH, 10'h005, 1'b0, hlst_pkg::ST_PUSHED, 6'd0},
      '{hlst_pkg::MODE_PUSH, 10'h009, 1'b0, hlst_pkg::ST_PUSHED, 6'd0},
      '{hlst_pkg::MODE_REMOVE, 10'h005, 1'b0, hlst_pkg::ST_PUSHED, 6'd0}, // topmost copy only
      '{hlst_pkg::MODE_REMOVE, 10'h3FF, 1'b1, hlst_pkg::ST_NOT_HELD, 6'd3},
      '{hlst_pkg::MODE_REMOVE, 10'h009, 1'b0, hlst_pkg::ST_PUSHED, 6'd0},
      '{hlst_pkg::MODE_REMOVE, 10'h005, 1'b0, hlst_pkg::ST_PUSHED, 6'd0},
      '{hlst_pkg::MODE_REMOVE, 10'h2AA, 1'b1, hlst_pkg::ST_REMOVED_TOP, 6'd0},
      '{hlst_pkg::MODE_REMOVE, 10'h2AA, 1'b1, hlst_pkg::ST_NOT_HELD, 6'd0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 3; ph++) begin
      run_phase = ph;
      case (ph)
        0: begin send_idle_pct = 32; recv_idle_pct = 80; end
        1: begin send_idle_pct = 80; recv_idle_pct = 32; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase

      if (ph == 0) begin
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
          row_res.status = directed_ops[r].status;
          row_res.depth  = directed_ops[r].depth;
          issue_op(directed_ops[r].mode, directed_ops[r].lock_id, directed_ops[r].typed,
                   row_res);
        end
      end

      // fill to the top, then push into a full stack and remove a random id from it
      while (held_depth < STACK_DEPTH)
        issue_op(hlst_pkg::MODE_PUSH, random_lock_id(), 1'b0, '0);
      issue_op(hlst_pkg::MODE_PUSH, random_lock_id(), 1'b0, '0);
      issue_op(hlst_pkg::MODE_REMOVE, random_lock_id(), 1'b0, '0);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 48 == 0) begin
          case ($urandom_range(0, 3))
            0: push_pct = 20;
            1: push_pct = 50;
            2: push_pct = 65;
            default: push_pct = 90;
          endcase
        end
        if ($urandom_range(0, 99) < push_pct) begin
          op_mode = hlst_pkg::MODE_PUSH;
          op_id   = random_lock_id();
        end else begin
          op_mode = hlst_pkg::MODE_REMOVE;
          if (held_depth != 0 && $urandom_range(0, 99) < 70)
            op_id = held_stack[$urandom_range(0, held_depth - 1)];
          else
            op_id = random_lock_id();
        end
        issue_op(op_mode, op_id, 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("ran %0d operations: %0d pushed, %0d overflow, %0d top removes,",
             ops_sent, status_seen[hlst_pkg::ST_PUSHED], status_seen[hlst_pkg::ST_OVERFLOW],
             status_seen[hlst_pkg::ST_REMOVED_TOP]);
    $display("%0d inner removes, %0d misses, peak depth %0d, %0d mismatches",
             status_seen[hlst_pkg::ST_REMOVED_INNER], status_seen[hlst_pkg::ST_NOT_HELD],
             peak_depth, mismatches);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("** held_lock_stack_tracker_core: PASSED **");
    end else begin
      $display("** held_lock_stack_tracker_core: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/hlst_pkg.sv
hw/rtl/hlst_in_if.sv
hw/rtl/hlst_out_if.sv
hw/rtl/hlst_datapath.sv
hw/rtl/hlst_ctrl.sv
hw/rtl/held_lock_stack_tracker_core.sv
tb/held_lock_stack_tracker_core_tb.sv
